// ----- rtl/mcst_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-channel second timer package
// Shared types and constants for the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mcst_pkg;

    localparam int CHANNELS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CHAN_W   = 4;
    localparam int PERIOD_W = 16;
    localparam int REPEAT_W = 8;

    localparam logic [REPEAT_W-1:0] REPEAT_ENDLESS = 8'hFF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic              fire;
        logic              flush;
        logic              fin;
        logic [CHAN_W-1:0] ch;
    } ev_t;

    typedef struct packed {
        logic stall;
        logic pend_valid;
    } buf_stat_t;

endpackage

`default_nettype wire

// ----- rtl/multi_channel_second_timer_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-channel second timer unit
// A bank of down-counting timer channels. A start transaction arms or
// restarts a channel, a stop transaction disarms it, and a tick transaction
// walks every channel in order through one shared update unit. Start and stop
// are applied as they are accepted. After a tick is accepted, every channel
// gets a read step, an armed channel also an update step, and a flush step
// closes the walk; the pace is set by the single read port of the channel
// state memory, and output back-pressure can stall the update and flush steps.
// Each channel that reaches zero yields one result, in channel order, with
// tlast on the last result of the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_second_timer_unit #(
    parameter int CHANNELS   = mcst_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = mcst_pkg::COUNT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // channel, reload_seconds, repeat_count, zero fill
    input  wire logic [1:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // fired_channel, zero fill
    output logic             m_tuser,   // final_expiry
    output logic             m_tlast    // last_of_tick
);

    localparam int IDX_W = $clog2(CHANNELS);

    mcst_pkg::state_t              state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [CHANNELS-1:0]           armed_reg, armed_next;

    logic [mcst_pkg::CHAN_W-1:0]   in_ch;
    logic [mcst_pkg::PERIOD_W-1:0] in_reload;
    logic [mcst_pkg::REPEAT_W-1:0] in_rep;
    logic [IDX_W-1:0]              in_idx;
    logic                          in_ch_ok;
    logic [COUNT_BITS-1:0]         period_raw;
    logic [COUNT_BITS-1:0]         period;
    logic [mcst_pkg::REPEAT_W-1:0] rep_init;
    logic [mcst_pkg::CHAN_W-1:0]   idx_ch;
    logic                          accept;
    logic                          idx_last;

    logic                          we_count, we_reload, we_rep;
    logic [IDX_W-1:0]              waddr;
    logic [COUNT_BITS-1:0]         wcount;
    logic [mcst_pkg::REPEAT_W-1:0] wrep;
    logic [COUNT_BITS-1:0]         rcount, rreload;
    logic [mcst_pkg::REPEAT_W-1:0] rrep;

    logic [COUNT_BITS-1:0]         count_new;
    logic [mcst_pkg::REPEAT_W-1:0] rep_new;
    logic                          alu_fire, alu_fin;

    mcst_pkg::ev_t                 ev;
    mcst_pkg::buf_stat_t           stat;

    assign in_ch     = s_tdata[3:0];
    assign in_reload = s_tdata[19:4];
    assign in_rep    = s_tdata[27:20];
    assign in_ch_ok  = {28'd0, in_ch} < 32'(CHANNELS);
    assign accept    = s_tvalid && s_tready;
    assign idx_last  = (idx_reg == IDX_W'(CHANNELS - 1));
    assign rep_init  = (in_rep == '0) ? 8'd1 : in_rep;
    assign period    = (period_raw == '0) ? COUNT_BITS'(1) : period_raw;

    generate
        if (COUNT_BITS > mcst_pkg::PERIOD_W)
        begin : g_period_wide
            assign period_raw = {{(COUNT_BITS - mcst_pkg::PERIOD_W){1'b0}}, in_reload};
        end
        else if (COUNT_BITS == mcst_pkg::PERIOD_W)
        begin : g_period_same
            assign period_raw = in_reload;
        end
        else
        begin : g_period_narrow
            assign period_raw = in_reload[COUNT_BITS-1:0];
        end

        if (IDX_W > mcst_pkg::CHAN_W)
        begin : g_idx_wide
            assign in_idx = {{(IDX_W - mcst_pkg::CHAN_W){1'b0}}, in_ch};
            assign idx_ch = idx_reg[mcst_pkg::CHAN_W-1:0];
        end
        else if (IDX_W == mcst_pkg::CHAN_W)
        begin : g_idx_same
            assign in_idx = in_ch;
            assign idx_ch = idx_reg;
        end
        else
        begin : g_idx_narrow
            assign in_idx = in_ch[IDX_W-1:0];
            assign idx_ch = {{(mcst_pkg::CHAN_W - IDX_W){1'b0}}, idx_reg};
        end
    endgenerate

    mcst_chan_mem #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_mem (
        .clk       (clk),
        .we_count  (we_count),
        .we_reload (we_reload),
        .we_rep    (we_rep),
        .waddr     (waddr),
        .wcount    (wcount),
        .wreload   (period),
        .wrep      (wrep),
        .raddr     (idx_reg),
        .rcount    (rcount),
        .rreload   (rreload),
        .rrep      (rrep)
    );

    mcst_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .count     (rcount),
        .reload    (rreload),
        .rep       (rrep),
        .count_new (count_new),
        .rep_new   (rep_new),
        .fire      (alu_fire),
        .fin       (alu_fin)
    );

    mcst_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        armed_next = armed_reg;
        s_tready   = 1'b0;
        we_count   = 1'b0;
        we_reload  = 1'b0;
        we_rep     = 1'b0;
        waddr      = idx_reg;
        wcount     = count_new;
        wrep       = rep_new;
        ev.fire    = 1'b0;
        ev.flush   = 1'b0;
        ev.fin     = alu_fin;
        ev.ch      = idx_ch;
        case (state_reg)
            mcst_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                waddr    = in_idx;
                wcount   = period;
                wrep     = rep_init;
                if (accept)
                begin
                    case (mcst_pkg::op_t'(s_tuser))
                        mcst_pkg::OP_START:
                        begin
                            if (in_ch_ok)
                            begin
                                we_count  = 1'b1;
                                we_reload = 1'b1;
                                we_rep    = !armed_reg[in_idx];
                                armed_next[in_idx] = 1'b1;
                            end
                        end
                        mcst_pkg::OP_STOP:
                        begin
                            if (in_ch_ok)
                            begin
                                armed_next[in_idx] = 1'b0;
                            end
                        end
                        mcst_pkg::OP_TICK:
                        begin
                            idx_next   = '0;
                            state_next = mcst_pkg::ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mcst_pkg::ST_READ:
            begin
                if (armed_reg[idx_reg])
                begin
                    state_next = mcst_pkg::ST_EXEC;
                end
                else if (idx_last)
                begin
                    state_next = mcst_pkg::ST_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            mcst_pkg::ST_EXEC:
            begin
                ev.fire = alu_fire;
                if (!stat.stall)
                begin
                    we_count = 1'b1;
                    we_rep   = 1'b1;
                    if (alu_fin)
                    begin
                        armed_next[idx_reg] = 1'b0;
                    end
                    if (idx_last)
                    begin
                        state_next = mcst_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = mcst_pkg::ST_READ;
                    end
                end
            end
            mcst_pkg::ST_FLUSH:
            begin
                ev.flush = 1'b1;
                if (!stat.stall)
                begin
                    state_next = mcst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcst_pkg::ST_IDLE;
            idx_reg   <= '0;
            armed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            armed_reg <= armed_next;
        end
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcst_pkg::ST_IDLE) |-> !stat.pend_valid)
        else $error("Pending result left over outside a tick walk.");

    a_exec_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcst_pkg::ST_EXEC) |-> armed_reg[idx_reg])
        else $error("Update step on a disarmed channel.");

    a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == mcst_pkg::OP_STOP) && in_ch_ok)
        |=> !armed_reg[$past(in_idx)])
        else $error("Channel still armed after a stop transaction.");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mcst_pkg::ST_IDLE) |-> ({{(32 - IDX_W){1'b0}}, idx_reg} < 32'(CHANNELS)))
        else $error("Walk index beyond the channel bank.");

    a_flush_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == mcst_pkg::ST_FLUSH && state_reg == mcst_pkg::ST_IDLE)
        |-> !stat.pend_valid)
        else $error("Tick walk closed with a result still pending.");

endmodule

`default_nettype wire

// ----- rtl/mcst_chan_mem.sv -----
// ----------------------------------------------------------------------------
// Channel state memory
// Count, repeat and reload storage with one write port and one registered
// read port; each field has its own write enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_chan_mem #(
    parameter int CHANNELS   = mcst_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = mcst_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              we_count,
    input  wire logic                              we_reload,
    input  wire logic                              we_rep,
    input  wire logic [$clog2(CHANNELS)-1:0]       waddr,
    input  wire logic [COUNT_BITS-1:0]             wcount,
    input  wire logic [COUNT_BITS-1:0]             wreload,
    input  wire logic [mcst_pkg::REPEAT_W-1:0]     wrep,
    input  wire logic [$clog2(CHANNELS)-1:0]       raddr,
    output logic      [COUNT_BITS-1:0]             rcount,
    output logic      [COUNT_BITS-1:0]             rreload,
    output logic      [mcst_pkg::REPEAT_W-1:0]     rrep
);

    logic [COUNT_BITS-1:0]         count_mem  [CHANNELS];
    logic [COUNT_BITS-1:0]         reload_mem [CHANNELS];
    logic [mcst_pkg::REPEAT_W-1:0] rep_mem    [CHANNELS];

    logic [COUNT_BITS-1:0]         rcount_reg;
    logic [COUNT_BITS-1:0]         rreload_reg;
    logic [mcst_pkg::REPEAT_W-1:0] rrep_reg;

    always_ff @(posedge clk)
    begin
        if (we_count)
        begin
            count_mem[waddr] <= wcount;
        end
        if (we_reload)
        begin
            reload_mem[waddr] <= wreload;
        end
        if (we_rep)
        begin
            rep_mem[waddr] <= wrep;
        end
    end

    always_ff @(posedge clk)
    begin
        rcount_reg  <= count_mem[raddr];
        rreload_reg <= reload_mem[raddr];
        rrep_reg    <= rep_mem[raddr];
    end

    assign rcount  = rcount_reg;
    assign rreload = rreload_reg;
    assign rrep    = rrep_reg;

endmodule

`default_nettype wire

// ----- rtl/mcst_alu.sv -----
// ----------------------------------------------------------------------------
// Channel update unit
// Shared decrement and compare unit applied to one channel per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_alu #(
    parameter int COUNT_BITS = mcst_pkg::COUNT_BITS_DEF
) (
    input  wire logic [COUNT_BITS-1:0]         count,
    input  wire logic [COUNT_BITS-1:0]         reload,
    input  wire logic [mcst_pkg::REPEAT_W-1:0] rep,
    output logic      [COUNT_BITS-1:0]         count_new,
    output logic      [mcst_pkg::REPEAT_W-1:0] rep_new,
    output logic                               fire,
    output logic                               fin
);

    logic [COUNT_BITS-1:0]         dec;
    logic [mcst_pkg::REPEAT_W-1:0] rep_dec;

    always_comb
    begin
        dec     = count - COUNT_BITS'(1);
        fire    = (dec == '0);
        rep_dec = (rep == mcst_pkg::REPEAT_ENDLESS) ? rep : rep - 8'd1;
        fin     = fire && (rep_dec == '0);
        rep_new = fire ? rep_dec : rep;
        count_new = (fire && !fin) ? reload : dec;
    end

endmodule

`default_nettype wire

// ----- rtl/mcst_out_buf.sv -----
// ----------------------------------------------------------------------------
// Result buffer
// Holds one pending result until the next one or the end of the walk
// decides its last flag, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_out_buf (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mcst_pkg::ev_t                   ev,
    output mcst_pkg::buf_stat_t                  stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // fired_channel, zero fill
    output logic                                 m_tuser,   // final_expiry
    output logic                                 m_tlast    // last_of_tick
);

    logic                        pend_valid_reg, pend_valid_next;
    logic [mcst_pkg::CHAN_W-1:0] pend_ch_reg, pend_ch_next;
    logic                        pend_fin_reg, pend_fin_next;
    logic                        out_valid_reg, out_valid_next;
    logic [mcst_pkg::CHAN_W-1:0] out_ch_reg, out_ch_next;
    logic                        out_fin_reg, out_fin_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || m_tready;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_fin_next   = pend_fin_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_ch_next     = out_ch_reg;
        out_fin_next    = out_fin_reg;
        out_last_next   = out_last_reg;
        stat.stall      = (ev.fire || ev.flush) && pend_valid_reg && !out_free;
        stat.pend_valid = pend_valid_reg;
        if (ev.fire && !stat.stall)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_ch_next    = pend_ch_reg;
                out_fin_next   = pend_fin_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_ch_next    = ev.ch;
            pend_fin_next   = ev.fin;
        end
        else if (ev.flush && !stat.stall && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_ch_next     = pend_ch_reg;
            out_fin_next    = pend_fin_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ch_reg  <= pend_ch_next;
        pend_fin_reg <= pend_fin_next;
        out_ch_reg   <= out_ch_next;
        out_fin_reg  <= out_fin_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_ch_reg};
    assign m_tuser  = out_fin_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- dv/tb_multi_channel_second_timer_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the multi-channel second timer unit
// Drives start, stop, tick and unused-opcode transactions into the timer bank
// and checks every expiry result against a behavioural model of the bank. A
// short directed table covers reset, extremes and the corner cases. A flood
// phase arms every channel while the result side holds off for a long
// stretch. The random part follows. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_channel_second_timer_unit;

    localparam int          NUM_CH       = 16;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 2 * NUM_CH + 8;
    localparam int          DIR_ROWS     = 24;
    localparam int          RAND_ITEMS   = 90;

    typedef struct packed {
        logic [mcst_pkg::CHAN_W-1:0] ch;
        logic                        fin;
        logic                        last;
    } expiry_t;

    typedef struct packed {
        logic [1:0]                    op;
        logic [mcst_pkg::CHAN_W-1:0]   ch;
        logic [mcst_pkg::PERIOD_W-1:0] reload;
        logic [mcst_pkg::REPEAT_W-1:0] rep;
        logic                          typed;
        logic                          has_exp;
        expiry_t                       exp_res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // channel, reload_seconds, repeat_count, zero fill
    logic [1:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // fired_channel, zero fill
    logic        m_tuser;   // final_expiry
    logic        m_tlast;   // last_of_tick

    logic                          chan_armed  [NUM_CH];
    logic [mcst_pkg::PERIOD_W-1:0] chan_count  [NUM_CH];
    logic [mcst_pkg::REPEAT_W-1:0] chan_repeats[NUM_CH];
    logic [mcst_pkg::PERIOD_W-1:0] chan_period [NUM_CH];

    expiry_t expiry_queue[$];
    int      mismatch_count = 0;
    int      sender_burst   = 0;
    logic    stall_request  = 1'b0;

    stim_row_t dir_table [DIR_ROWS] = '{
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_STOP,  4'd5,  16'd0,    8'd0,   1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_START, 4'd0,  16'd0,    8'd0,   1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b1, 1'b1, '{4'd0,  1'b1, 1'b1}},
        '{mcst_pkg::OP_TICK,  4'd15, 16'hFFFF, 8'hFF,  1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_START, 4'd15, 16'd1,    8'd255, 1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b1, 1'b1, '{4'd15, 1'b0, 1'b1}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b1, 1'b1, '{4'd15, 1'b0, 1'b1}},
        '{mcst_pkg::OP_START, 4'd15, 16'd3,    8'd1,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_START, 4'd3,  16'd2,    8'd2,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{OP_UNUSED,          4'd3,  16'hFFFF, 8'hFF,  1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_START, 4'd7,  16'hFFFF, 8'd1,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_START, 4'd1,  16'd1,    8'd1,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_START, 4'd2,  16'd1,    8'd255, 1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_STOP,  4'd15, 16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_STOP,  4'd2,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_STOP,  4'd7,  16'd0,    8'd0,   1'b0, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_STOP,  4'd7,  16'd0,    8'd0,   1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}},
        '{mcst_pkg::OP_TICK,  4'd0,  16'd0,    8'd0,   1'b1, 1'b0, '{4'd0,  1'b0, 1'b0}}
    };

    multi_channel_second_timer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic advance_timer_bank(input logic [1:0]                    op,
                                      input logic [mcst_pkg::CHAN_W-1:0]   ch,
                                      input logic [mcst_pkg::PERIOD_W-1:0] reload,
                                      input logic [mcst_pkg::REPEAT_W-1:0] rep,
                                      input bit                            enqueue);
        logic [mcst_pkg::PERIOD_W-1:0] period;
        expiry_t                       fired[$];
        expiry_t                       res;
        period = (reload == '0) ? mcst_pkg::PERIOD_W'(1) : reload;
        case (op)
            mcst_pkg::OP_START:
            begin
                chan_count[ch]  = period;
                chan_period[ch] = period;
                if (!chan_armed[ch])
                begin
                    chan_repeats[ch] = (rep == '0) ? mcst_pkg::REPEAT_W'(1) : rep;
                    chan_armed[ch]   = 1'b1;
                end
            end
            mcst_pkg::OP_STOP:
                chan_armed[ch] = 1'b0;
            mcst_pkg::OP_TICK:
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (chan_armed[i])
                    begin
                        chan_count[i] = chan_count[i] - mcst_pkg::PERIOD_W'(1);
                        if (chan_count[i] == '0)
                        begin
                            if (chan_repeats[i] != mcst_pkg::REPEAT_ENDLESS)
                                chan_repeats[i] = chan_repeats[i] - mcst_pkg::REPEAT_W'(1);
                            res.ch   = mcst_pkg::CHAN_W'(i);
                            res.fin  = (chan_repeats[i] == '0);
                            res.last = 1'b0;
                            if (res.fin)
                                chan_armed[i] = 1'b0;
                            else
                                chan_count[i] = chan_period[i];
                            fired.push_back(res);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (fired.size() > 0)
            fired[fired.size() - 1].last = 1'b1;
        if (enqueue)
        begin
            foreach (fired[k])
                expiry_queue.push_back(fired[k]);
        end
    endtask

    task automatic send_item(input logic [1:0]                    op,
                             input logic [mcst_pkg::CHAN_W-1:0]   ch,
                             input logic [mcst_pkg::PERIOD_W-1:0] reload,
                             input logic [mcst_pkg::REPEAT_W-1:0] rep,
                             input bit                            typed,
                             input bit                            has_exp,
                             input expiry_t                       typed_res);
        int gap;
        int r;
        if (sender_burst > 0)
        begin
            sender_burst--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 4)
                sender_burst = 20;
            gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, rep, reload, ch};
        do
            @(posedge clk);
        while (!s_tready);
        advance_timer_bank(op, ch, reload, rep, !typed);
        if (typed && has_exp)
        begin
            expiry_queue.push_back(typed_res);
        end
    endtask

    initial
    begin
        int   hold_left;
        int   free_left;
        int   r;
        bit   stall_done;
        expiry_t exp_res;
        hold_left  = 0;
        free_left  = 0;
        stall_done = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expiry_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual channel %0d",
                             $time, m_tdata[mcst_pkg::CHAN_W-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = expiry_queue.pop_front();
                    if (m_tdata[mcst_pkg::CHAN_W-1:0] !== exp_res.ch)
                    begin
                        $display("%0t: fired_channel expected %0d actual %0d",
                                 $time, exp_res.ch, m_tdata[mcst_pkg::CHAN_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tuser !== exp_res.fin)
                    begin
                        $display("%0t: final_expiry expected %0b actual %0b",
                                 $time, exp_res.fin, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tlast !== exp_res.last)
                    begin
                        $display("%0t: last_of_tick expected %0b actual %0b",
                                 $time, exp_res.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_request && !stall_done)
            begin
                stall_done = 1'b1;
                hold_left  = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (free_left > 0)
            begin
                free_left--;
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 3)
                begin
                    free_left = 60;
                    m_tready <= 1'b1;
                end
                else if (r < 65)
                    m_tready <= 1'b1;
                else
                begin
                    hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int                            r;
        int                            sel;
        logic [1:0]                    op;
        logic [mcst_pkg::PERIOD_W-1:0] reload;
        logic [mcst_pkg::REPEAT_W-1:0] rep;
        stim_row_t                     row;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        foreach (chan_armed[i])
            chan_armed[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[k])
        begin
            row = dir_table[k];
            send_item(row.op, row.ch, row.reload, row.rep, row.typed, row.has_exp, row.exp_res);
        end

        // Arm every channel so that each tick fires all of them while the
        // result side is held off and the bank has to stall its input.
        for (int c = 0; c < NUM_CH; c++)
            send_item(mcst_pkg::OP_START, mcst_pkg::CHAN_W'(c), mcst_pkg::PERIOD_W'(1),
                      mcst_pkg::REPEAT_ENDLESS, 1'b0, 1'b0, '0);
        stall_request <= 1'b1;
        repeat (3) send_item(mcst_pkg::OP_TICK, '0, '0, '0, 1'b0, 1'b0, '0);
        for (int c = 0; c < NUM_CH; c++)
            send_item(mcst_pkg::OP_STOP, mcst_pkg::CHAN_W'(c), '0, '0, 1'b0, 1'b0, '0);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            r  = $urandom_range(99);
            if (r < 30)
                op = mcst_pkg::OP_START;
            else if (r < 40)
                op = mcst_pkg::OP_STOP;
            else if (r < 95)
                op = mcst_pkg::OP_TICK;
            else
                op = OP_UNUSED;
            sel = $urandom_range(9);
            if (sel < 6)
                reload = mcst_pkg::PERIOD_W'($urandom_range(0, 4));
            else if (sel < 8)
                reload = mcst_pkg::PERIOD_W'($urandom_range(0, 20));
            else if (sel < 9)
                reload = mcst_pkg::PERIOD_W'($urandom());
            else
                reload = '1;
            sel = $urandom_range(9);
            if (sel < 6)
                rep = mcst_pkg::REPEAT_W'($urandom_range(0, 4));
            else if (sel < 8)
                rep = mcst_pkg::REPEAT_ENDLESS;
            else
                rep = mcst_pkg::REPEAT_W'($urandom_range(255));
            send_item(op, mcst_pkg::CHAN_W'($urandom_range(15)), reload, rep, 1'b0, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expiry_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mcst_pkg.sv
rtl/mcst_chan_mem.sv
rtl/mcst_alu.sv
rtl/mcst_out_buf.sv
rtl/multi_channel_second_timer_unit.sv
dv/tb_multi_channel_second_timer_unit.sv
